@@ rtl/pressure_temperature_compensation_assert.svh @@
// Assertion macros for the compensation pipeline.
// No dependencies; included by modules that carry assertions.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define PTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/ptc_pkg.sv @@
// Constants and register index codes for the compensation pipeline.
// No dependencies.
package ptc_pkg;

	localparam int DIV_BITS   = 64;
	localparam int DIV_FIRST  = 12;
	localparam int DIV_LAST   = DIV_FIRST + DIV_BITS;
	localparam int PIPE_LAST  = DIV_LAST + 8;

	localparam logic [33:0] FINE_OFFSET = 34'd128000;
	localparam logic [20:0] P_FULL      = 21'd1048576;
	localparam logic [11:0] NUM_SCALE   = 12'd3125;
	localparam logic [63:0] W_BIAS      = 64'h0000_8000_0000_0000;

	typedef enum logic [7:0] {
		REG_TEMP_COEF  = 8'd0,
		REG_PRESS_LOW  = 8'd1,
		REG_PRESS_MID  = 8'd2,
		REG_PRESS_NINE = 8'd3
	} cfg_index_t;

endpackage

@@ rtl/pressure_temperature_compensation.sv @@
// Pressure/temperature compensation pipeline, top level.
// Depends on ptc_pkg and pressure_temperature_compensation_assert.svh.
`include "pressure_temperature_compensation_assert.svh"

// Fully pipelined: one sample per clock while the skid is empty; the output
// register drives the output port directly. The depth is set by the signed
// 64-bit divider, which resolves one quotient bit per stage over 64 stages.
// A skid register behind the output lets one more result land while the output
// is stalled; the input is held off only when that is full. The user must write
// coefficients over the cfg port while the pipeline is empty; nothing checks it.
module pressure_temperature_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // temperature_centi[31:0], pressure_pa[63:32]
	output logic        m_axis_tuser,  // divisor_zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int DF = ptc_pkg::DIV_FIRST;
	localparam int DL = ptc_pkg::DIV_LAST;
	localparam int PL = ptc_pkg::PIPE_LAST;

	// configuration
	logic [47:0] temp_coef_q;
	logic [63:0] press_low_q;
	logic [63:0] press_mid_q;
	logic [15:0] press_nine_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q  <= '0;
			press_low_q  <= '0;
			press_mid_q  <= '0;
			press_nine_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptc_pkg::REG_TEMP_COEF:  temp_coef_q  <= cfg_data[47:0];
				ptc_pkg::REG_PRESS_LOW:  press_low_q  <= cfg_data;
				ptc_pkg::REG_PRESS_MID:  press_mid_q  <= cfg_data;
				ptc_pkg::REG_PRESS_NINE: press_nine_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic        [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_coef_q[15:0];
	assign t2 = $signed(temp_coef_q[31:16]);
	assign t3 = $signed(temp_coef_q[47:32]);
	assign p1 = press_low_q[15:0];
	assign p2 = $signed(press_low_q[31:16]);
	assign p3 = $signed(press_low_q[47:32]);
	assign p4 = $signed(press_low_q[63:48]);
	assign p5 = $signed(press_mid_q[15:0]);
	assign p6 = $signed(press_mid_q[31:16]);
	assign p7 = $signed(press_mid_q[47:32]);
	assign p8 = $signed(press_mid_q[63:48]);
	assign p9 = $signed(press_nine_q);

	// pipeline control
	logic          en;
	logic [PL:1]   vld_q;
	logic          skid_v_q, out_v_q;

	assign en = !skid_v_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PL-1:1], s_axis_tvalid};
		end
	end

	// side lines
	logic [19:0] adcp_s [1:8];
	logic [31:0] temp_s [5:PL];
	logic        zero_s [DF:PL];

	// temperature path
	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic signed [33:0] m1_full, sqf_full;
	logic        [31:0] m1_s2, sq_s2;
	logic signed [31:0] sq_sh;
	logic signed [47:0] m2_full;
	logic signed [31:0] a1_s3;
	logic        [31:0] m2_s3;
	logic signed [31:0] fine_s4;
	logic        [31:0] f5;
	logic signed [33:0] v1_s5;

	assign m1_full  = d1_s1 * t2;
	assign sqf_full = d2_s1 * d2_s1;
	assign sq_sh    = $signed(sq_s2) >>> 12;
	assign m2_full  = sq_sh * t3;
	assign f5       = fine_s4 + {fine_s4[29:0], 2'b00} + 32'd128;

	// pressure path before the divider
	logic signed [67:0] vv_full;
	logic        [63:0] vv_s6;
	logic signed [49:0] vp5_s6, vp2_s6, vp2_s7, vp2_s8;
	logic signed [49:0] vp5_s7;
	logic signed [48:0] x6lo_full, x3lo_full, x6lo_s7, x3lo_s7;
	logic signed [47:0] x6hi_full, x3hi_full;
	logic        [31:0] x6hi_s7, x3hi_s7;
	logic        [63:0] x6, x3_s8, v2_s8;
	logic        [63:0] w_s9, n_s9;
	logic        [20:0] p0;
	logic        [47:0] wlo_s10;
	logic        [47:0] whi_full;
	logic        [31:0] whi_s10;
	logic        [43:0] nlo_s10, nhi_full;
	logic        [31:0] nhi_s10;
	logic        [63:0] dvf, dv_s11, num_s11;

	assign vv_full   = v1_s5 * v1_s5;
	assign x6lo_full = $signed({1'b0, vv_s6[31:0]}) * p6;
	assign x6hi_full = $signed(vv_s6[63:32]) * p6;
	assign x3lo_full = $signed({1'b0, vv_s6[31:0]}) * p3;
	assign x3hi_full = $signed(vv_s6[63:32]) * p3;
	assign x6 = {{15{x6lo_s7[48]}}, x6lo_s7} + {x6hi_s7, 32'd0};
	assign p0 = ptc_pkg::P_FULL - {1'b0, adcp_s[8]};
	assign whi_full = w_s9[63:32] * p1;
	assign nhi_full = n_s9[63:32] * ptc_pkg::NUM_SCALE;
	assign dvf = {16'd0, wlo_s10} + {whi_s10, 32'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			d1_s1 <= $signed({1'b0, s_axis_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
			d2_s1 <= $signed({1'b0, s_axis_tdata[19:4]}) - $signed({1'b0, t1});
			adcp_s[1] <= s_axis_tdata[39:20];
			for (int i = 2; i <= 8; i++) adcp_s[i] <= adcp_s[i-1];
			// s2
			m1_s2 <= m1_full[31:0];
			sq_s2 <= sqf_full[31:0];
			// s3
			a1_s3 <= $signed(m1_s2) >>> 11;
			m2_s3 <= m2_full[31:0];
			// s4
			fine_s4 <= a1_s3 + ($signed(m2_s3) >>> 14);
			// s5
			temp_s[5] <= $signed(f5) >>> 8;
			v1_s5 <= {{2{fine_s4[31]}}, fine_s4} - ptc_pkg::FINE_OFFSET;
			for (int i = 6; i <= PL; i++) temp_s[i] <= temp_s[i-1];
			// s6
			vv_s6  <= vv_full[63:0];
			vp5_s6 <= v1_s5 * p5;
			vp2_s6 <= v1_s5 * p2;
			// s7
			x6lo_s7 <= x6lo_full;
			x6hi_s7 <= x6hi_full[31:0];
			x3lo_s7 <= x3lo_full;
			x3hi_s7 <= x3hi_full[31:0];
			vp5_s7  <= vp5_s6;
			vp2_s7  <= vp2_s6;
			// s8
			v2_s8 <= x6 + ({{14{vp5_s7[49]}}, vp5_s7} << 17)
				+ ({{48{p4[15]}}, p4} << 35);
			x3_s8 <= {{15{x3lo_s7[48]}}, x3lo_s7} + {x3hi_s7, 32'd0};
			vp2_s8 <= vp2_s7;
			// s9
			w_s9 <= ptc_pkg::W_BIAS + 64'($signed(x3_s8) >>> 8)
				+ ({{14{vp2_s8[49]}}, vp2_s8} << 12);
			n_s9 <= ({43'd0, p0} << 31) - v2_s8;
			// s10
			wlo_s10 <= w_s9[31:0] * p1;
			whi_s10 <= whi_full[31:0];
			nlo_s10 <= n_s9[31:0] * ptc_pkg::NUM_SCALE;
			nhi_s10 <= nhi_full[31:0];
			// s11
			dv_s11  <= $signed(dvf) >>> 33;
			num_s11 <= {20'd0, nlo_s10} + {nhi_s10, 32'd0};
		end
	end

	// signed divider: sign/magnitude prep, then one quotient bit per stage
	logic [63:0] rem_s [DF:DL];
	logic [63:0] dvd_s [DF:DL];
	logic [63:0] dsr_s [DF:DL];
	logic        neg_s [DF:DL];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[DF] <= '0;
			dvd_s[DF] <= num_s11[63] ? 64'd0 - num_s11 : num_s11;
			dsr_s[DF] <= dv_s11[63] ? 64'd0 - dv_s11 : dv_s11;
			neg_s[DF] <= num_s11[63] ^ dv_s11[63];
			zero_s[DF] <= dv_s11 == 64'd0;
			for (int i = DF + 1; i <= PL; i++) zero_s[i] <= zero_s[i-1];
		end
	end

	for (genvar k = DF; k < DL; k++) begin : g_div
		logic [64:0] rsh;
		logic        ge;
		assign rsh = {rem_s[k], dvd_s[k][63]};
		assign ge  = rsh >= {1'b0, dsr_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? 64'(rsh - {1'b0, dsr_s[k]}) : rsh[63:0];
				dvd_s[k+1] <= {dvd_s[k][62:0], ge};
				dsr_s[k+1] <= dsr_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// pressure path after the divider
	logic        [63:0] p_a, p_b, ph;
	logic        [63:0] pll_b;
	logic        [31:0] pc_b;
	logic signed [48:0] p8lo_full, p8lo_b;
	logic signed [47:0] p8hi_full;
	logic        [31:0] p8hi_b;
	logic        [63:0] sqq, x8, sq_c, v2_c, v2_d, p_c, p_d;
	logic signed [48:0] p9lo_full, p9lo_d;
	logic signed [47:0] p9hi_full;
	logic        [31:0] p9hi_d;
	logic        [63:0] x9_e, v2_e, p_e, sum_f, r_g, r_adj;
	logic        [31:0] press_h;

	assign ph        = $signed(p_a) >>> 13;
	assign p8lo_full = $signed({1'b0, p_a[31:0]}) * p8;
	assign p8hi_full = $signed(p_a[63:32]) * p8;
	assign sqq       = pll_b + {pc_b[30:0], 1'b0, 32'd0};
	assign x8        = {{15{p8lo_b[48]}}, p8lo_b} + {p8hi_b, 32'd0};
	assign p9lo_full = $signed({1'b0, sq_c[31:0]}) * p9;
	assign p9hi_full = $signed(sq_c[63:32]) * p9;
	assign r_adj     = r_g + (r_g[63] ? 64'd255 : 64'd0);

	always_ff @(posedge clk) begin
		if (en) begin
			p_a    <= neg_s[DL] ? 64'd0 - dvd_s[DL] : dvd_s[DL];
			pll_b  <= ph[31:0] * ph[31:0];
			pc_b   <= 32'(ph[31:0] * ph[63:32]);
			p8lo_b <= p8lo_full;
			p8hi_b <= p8hi_full[31:0];
			p_b    <= p_a;
			sq_c   <= sqq;
			v2_c   <= $signed(x8) >>> 19;
			p_c    <= p_b;
			p9lo_d <= p9lo_full;
			p9hi_d <= p9hi_full[31:0];
			v2_d   <= v2_c;
			p_d    <= p_c;
			x9_e   <= {{15{p9lo_d[48]}}, p9lo_d} + {p9hi_d, 32'd0};
			v2_e   <= v2_d;
			p_e    <= p_d;
			sum_f  <= p_e + 64'($signed(x9_e) >>> 25) + v2_e;
			r_g    <= 64'($signed(sum_f) >>> 8) + ({{48{p7[15]}}, p7} << 4);
			press_h <= zero_s[PL-1] ? 32'd0 : r_adj[39:8];
		end
	end

	// output register and skid
	logic [31:0] out_temp_q, skid_temp_q, out_press_q, skid_press_q;
	logic        out_zero_q, skid_zero_q;
	logic        out_free;

	assign out_free = !out_v_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_free) begin
			if (en && vld_q[PL]) skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= en && vld_q[PL];
		end
	end

	always_ff @(posedge clk) begin
		if (!out_free) begin
			if (en && vld_q[PL]) begin
				skid_temp_q  <= temp_s[PL];
				skid_press_q <= press_h;
				skid_zero_q  <= zero_s[PL];
			end
		end else if (skid_v_q) begin
			out_temp_q  <= skid_temp_q;
			out_press_q <= skid_press_q;
			out_zero_q  <= skid_zero_q;
		end else begin
			out_temp_q  <= temp_s[PL];
			out_press_q <= press_h;
			out_zero_q  <= zero_s[PL];
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_press_q, out_temp_q};
	assign m_axis_tuser  = out_zero_q;

	`PTC_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_v_q, out_v_q)
	`PTC_ASSERT_IMP(a_zero_forces_press, clk, arst_n, out_v_q && out_zero_q, out_press_q == 32'd0)
	`PTC_ASSERT_NXT(a_stall_fills_skid, clk, arst_n,
		out_v_q && !m_axis_tready && !skid_v_q && vld_q[PL], skid_v_q)

endmodule
